/* design/iirl_pkg.sv */
// ----------------------------------------------------------------------------
// iirl_pkg: shared types and constants of the indexed insert/remove list
// Sizes of the list, operation and status codes, and the control word that
// the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package iirl_pkg;

    // list geometry
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);

    // fixed port widths
    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;

    // read-out tree: cells are or-ed in registered groups
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_POP    = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_READ   = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // control word seen by every cell in the same cycle
    typedef struct packed {
        logic             ins;   // shift up at and above pos, write word at pos
        logic             rem;   // shift down at and above pos
        logic [IDX_W-1:0] pos;   // operation index, also the read select
        word_t            word;  // word to insert
    } cell_ctrl_t;

endpackage

/* design/indexed_insert_remove_list_top.sv */
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_top: ordered list with indexed insert and remove
// Row of entry cells that all shift in the same cycle, an operation decoder, a
// two-level read-out tree and an output register.
// ----------------------------------------------------------------------------
// Takes one operation per item (append, insert at position, pop, remove at
// position, read at position) and returns one result item with status, word
// read, entry count and empty flag. Every entry cell moves in the same cycle
// the item is accepted; the result is registered in the group registers and
// then in the output register, since the read path goes through a registered
// or-tree over all cells (group stage, then final stage into the output
// register). A new item is not taken while the last one waits in the first
// stage, but one is taken while a finished result still waits on the output.
// Entries need no clearing after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [iirl_pkg::MODE_W-1:0]     s_mode,
    input  logic [iirl_pkg::POS_W-1:0]      s_position,
    input  logic [iirl_pkg::VALUE_W-1:0]    s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [iirl_pkg::STATUS_W-1:0]   m_status,
    output logic [iirl_pkg::VALUE_W-1:0]    m_read_value,
    output logic [iirl_pkg::CNT_W-1:0]      m_count,
    output logic                            m_is_empty
);
    import iirl_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             s1_valid_reg;
    status_t          s1_status_reg;
    logic [CNT_W-1:0] s1_count_reg;
    logic             s1_rd_ok_reg;

    logic             out_valid_reg;
    status_t          out_status_reg;
    word_t            out_read_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_empty_reg;

    logic             in_fire;
    logic             s1_move;
    status_t          status_c;
    logic             rd_ok_c;
    logic             full_c;
    cell_ctrl_t       ctrl;
    word_t            read_or;

    word_t            entry_data[CAPACITY];
    word_t            sel_data  [CAPACITY];
    word_t            group_data[NUM_GROUPS];

    // handshakes
    assign s_ready = !s1_valid_reg;
    assign in_fire = s_valid && s_ready;
    assign s1_move = s1_valid_reg && (!out_valid_reg || m_ready);
    assign full_c  = (count_reg >= CNT_W'(CAPACITY));

    // operation decode
    always_comb begin
        status_c   = ST_OK;
        rd_ok_c    = 1'b0;
        count_next = count_reg;
        ctrl.ins   = 1'b0;
        ctrl.rem   = 1'b0;
        ctrl.pos   = s_position[IDX_W-1:0];
        ctrl.word  = s_value[DATA_WIDTH-1:0];
        case (s_mode)
            MODE_APPEND: begin
                ctrl.pos = count_reg[IDX_W-1:0];
                if (full_c) begin
                    status_c = ST_FULL;
                end else begin
                    ctrl.ins   = in_fire;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_INSERT: begin
                if (s_position > count_reg) begin
                    status_c = ST_RANGE;
                end else if (full_c) begin
                    status_c = ST_FULL;
                end else begin
                    ctrl.ins   = in_fire;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_POP: begin
                if (count_reg == '0) begin
                    status_c = ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (s_position >= count_reg) begin
                    status_c = ST_RANGE;
                end else begin
                    ctrl.rem   = in_fire;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_READ: begin
                if (s_position >= count_reg) begin
                    status_c = ST_RANGE;
                end else begin
                    rd_ok_c = 1'b1;
                end
            end
            default: begin
                status_c = ST_RANGE;
            end
        endcase
    end

    // row of entry cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        word_t lower_w;
        word_t upper_w;
        if (i == 0) begin : g_first
            assign lower_w = '0;
        end else begin : g_mid_lo
            assign lower_w = entry_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign upper_w = '0;
        end else begin : g_mid_hi
            assign upper_w = entry_data[i+1];
        end
        iirl_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_idx   (IDX_W'(i)),
            .lower_data (lower_w),
            .upper_data (upper_w),
            .entry_data (entry_data[i]),
            .sel_data   (sel_data[i])
        );
    end

    // first read-out level
    iirl_read_tree u_read_tree (
        .aclk       (aclk),
        .load       (in_fire),
        .sel_data   (sel_data),
        .group_data (group_data)
    );

    // final read-out level
    always_comb begin
        read_or = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            read_or = read_or | group_data[g];
        end
    end

    // entry count and first stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                count_reg    <= count_next;
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // first stage payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_status_reg <= status_c;
            s1_count_reg  <= count_next;
            s1_rd_ok_reg  <= rd_ok_c;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            out_status_reg <= s1_status_reg;
            out_read_reg   <= s1_rd_ok_reg ? read_or : '0;
            out_count_reg  <= s1_count_reg;
            out_empty_reg  <= (s1_count_reg == '0);
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_read_value = VALUE_W'(out_read_reg);
    assign m_count      = out_count_reg;
    assign m_is_empty   = out_empty_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_fail_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && status_c != ST_OK |=> $stable(count_reg))
        else $error("failed operation changed the count");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && out_valid_reg && !m_ready |=> s1_valid_reg)
        else $error("pending item lost while output stalled");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_count == '0)))
        else $error("empty flag disagrees with count");

    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_read_value == '0)
        else $error("read word nonzero on failed item");

endmodule

/* design/iirl_cell.sv */
// ----------------------------------------------------------------------------
// iirl_cell: one entry of the list
// Holds one word and, on an insert or remove, takes the word of its lower or
// upper neighbor, or the new word. Also drives its word onto the read-out
// tree when it is the selected index.
// ----------------------------------------------------------------------------
module iirl_cell (
    input  logic                          aclk,
    input  iirl_pkg::cell_ctrl_t          ctrl,
    input  logic [iirl_pkg::IDX_W-1:0]    cell_idx,
    input  iirl_pkg::word_t               lower_data,
    input  iirl_pkg::word_t               upper_data,
    output iirl_pkg::word_t               entry_data,
    output iirl_pkg::word_t               sel_data
);
    import iirl_pkg::*;

    word_t entry_reg;
    word_t entry_next;
    logic  at_pos;
    logic  above_pos;

    // position of this cell relative to the operation index
    assign at_pos    = (cell_idx == ctrl.pos);
    assign above_pos = (cell_idx > ctrl.pos);

    // next entry value
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (at_pos) begin
                entry_next = ctrl.word;
            end else if (above_pos) begin
                entry_next = lower_data;
            end
        end else if (ctrl.rem) begin
            if (at_pos || above_pos) begin
                entry_next = upper_data;
            end
        end
    end

    // entry storage, payload only
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_data = entry_reg;
    assign sel_data   = at_pos ? entry_reg : '0;

endmodule

/* design/iirl_read_tree.sv */
// ----------------------------------------------------------------------------
// iirl_read_tree: first level of the read-out or-tree
// Or-reduces the selected cell words in groups and registers one word per
// group when an item is accepted.
// ----------------------------------------------------------------------------
module iirl_read_tree (
    input  logic            aclk,
    input  logic            load,
    input  iirl_pkg::word_t sel_data  [iirl_pkg::CAPACITY],
    output iirl_pkg::word_t group_data[iirl_pkg::NUM_GROUPS]
);
    import iirl_pkg::*;

    word_t group_reg [NUM_GROUPS];
    word_t group_next[NUM_GROUPS];

    // or of each group of cells
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < CAPACITY) begin
                    group_next[g] = group_next[g] | sel_data[g * GROUP_SIZE + k];
                end
            end
        end
    end

    // group registers
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    assign group_data = group_reg;

endmodule
